/* hw/rtl/pgd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Parking gap detector package
// Shared types, register indexes and constants for the parking gap detector.
// ----------------------------------------------------------------------------
package pgd_pkg;

  localparam int DIST_W = 9;
  localparam int COUNT_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [COUNT_W-1:0] GAP_COUNT_MAX = 8'd255;

  // Register reset values.
  localparam logic [DIST_W-1:0] SIDE_CLOSE_RST = 9'd25;
  localparam logic [DIST_W-1:0] SIDE_FAR_RST = 9'd35;
  localparam logic [DIST_W-1:0] GAP_JUMP_RST = 9'd8;
  localparam logic [COUNT_W-1:0] MIN_GAP_RST = 8'd11;
  localparam logic [DIST_W-1:0] FRONT_STOP_RST = 9'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_CLOSE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_FAR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_JUMP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_STOP = 3'd4;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    ACT_FORWARD = 2'd0,
    ACT_AVOID = 2'd1,
    ACT_PARK = 2'd2,
    ACT_HOLD = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_COUNT = 2'd1,
    PH_PARKED = 2'd2
  } phase_t;

  typedef struct packed {
    dist_t side_close;
    dist_t side_far;
    dist_t gap_jump;
    count_t min_gap;
    dist_t front_stop;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    dist_t last_side;
    count_t gap_count;
    logic wall_seen;
  } search_state_t;

endpackage

`default_nettype wire

/* hw/rtl/pgd_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor request channel
// Valid/ready channel carrying one pair of filtered distances per request.
// ----------------------------------------------------------------------------
interface pgd_in_if
  import pgd_pkg::*;
();
  logic valid;
  logic ready;
  dist_t side_dist;
  dist_t front_dist;
  logic clear_search;

  modport source (output valid, output side_dist, output front_dist,
                  output clear_search, input ready);
  modport sink (input valid, input side_dist, input front_dist,
                input clear_search, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pgd_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command request channel
// Valid/ready channel carrying one robot command per request.
// ----------------------------------------------------------------------------
interface pgd_out_if
  import pgd_pkg::*;
();
  logic valid;
  logic ready;
  action_t action;
  phase_t phase;
  count_t gap_steps;

  modport source (output valid, output action, output phase,
                  output gap_steps, input ready);
  modport sink (input valid, input action, input phase,
                input gap_steps, output ready);
endinterface

`default_nettype wire

/* hw/rtl/parking_gap_detector_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Parking gap detector unit
// Decides the robot's next move from one pair of filtered distances per step.
//
// The sensor channel takes one request per search step (side distance, front
// distance, clear flag); the command channel returns exactly one request per
// step with the action, the phase after the step and the gap step count.
// Both channels are valid/ready: a request moves when valid and ready are high
// at a rising edge of clk.
// A request taken is held in the input register, decided and placed in the
// result register once that is free or drains. Throughput is one step per
// cycle while the receiver takes commands, set by the single search state
// register that each step reads and updates as it moves from the input register
// to the result register. When the receiver stalls, the result register holds
// its command and the input register still takes one more request; further
// requests wait. Synchronous reset empties both registers, restores the
// thresholds to their defaults and clears the search state. The user writes
// thresholds through the write port only while the unit is idle; the unit does not enforce it.
// ----------------------------------------------------------------------------
module parking_gap_detector_unit
  import pgd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  pgd_in_if.sink                     sensor,
  pgd_out_if.source                  command
);

  cfg_t          cfg;
  search_state_t state;
  search_state_t state_next;
  action_t       step_action;

  logic  in_valid;
  dist_t in_side;
  dist_t in_front;
  logic  in_clear;
  logic  advance;

  pgd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The stored request moves on when the result register is free or drains.
  assign advance = in_valid && (!command.valid || command.ready);
  assign sensor.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sensor.ready) begin
      in_valid <= sensor.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sensor.valid && sensor.ready) begin
      in_side <= sensor.side_dist;
      in_front <= sensor.front_dist;
      in_clear <= sensor.clear_search;
    end
  end

  pgd_step u_step (
    .cfg          (cfg),
    .state        (state),
    .side_dist    (in_side),
    .front_dist   (in_front),
    .clear_search (in_clear),
    .state_next   (state_next),
    .action       (step_action)
  );

  // Search state register, updated once per decided step.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_SEARCH, last_side: '0, gap_count: '0, wall_seen: 1'b0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      command.valid <= 1'b0;
    end else if (advance) begin
      command.valid <= 1'b1;
    end else if (command.ready) begin
      command.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      command.action <= step_action;
      command.phase <= state_next.phase;
      command.gap_steps <= state_next.gap_count;
    end
  end

  // The search state changes only when a step is decided.
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("search state changed without a step");

  // A park command always reports the latched parked phase.
  assert property (@(posedge clk) disable iff (rst)
    command.valid && (command.action == ACT_PARK) |-> command.phase == PH_PARKED)
    else $error("park command outside parked phase");

  // Hold is answered only once parked.
  assert property (@(posedge clk) disable iff (rst)
    command.valid && (command.action == ACT_HOLD) |-> command.phase == PH_PARKED)
    else $error("hold command outside parked phase");

  // Any decided step shows up in the result register at the next edge.
  assert property (@(posedge clk) disable iff (rst)
    advance |=> command.valid)
    else $error("decided step lost");

endmodule

`default_nettype wire

/* hw/rtl/pgd_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Parking gap detector configuration registers
// Holds the five threshold registers written through the plain write port.
// ----------------------------------------------------------------------------
module pgd_cfg_regs
  import pgd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  // Register file; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.side_close <= SIDE_CLOSE_RST;
      cfg.side_far <= SIDE_FAR_RST;
      cfg.gap_jump <= GAP_JUMP_RST;
      cfg.min_gap <= MIN_GAP_RST;
      cfg.front_stop <= FRONT_STOP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIDE_CLOSE: cfg.side_close <= cfg_data;
        REG_SIDE_FAR: cfg.side_far <= cfg_data;
        REG_GAP_JUMP: cfg.gap_jump <= cfg_data;
        REG_MIN_GAP: cfg.min_gap <= cfg_data[COUNT_W-1:0];
        REG_FRONT_STOP: cfg.front_stop <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pgd_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Parking gap detector step logic
// Combinational decision for one search step: next search state and action.
// ----------------------------------------------------------------------------
module pgd_step
  import pgd_pkg::*;
(
  input  wire cfg_t            cfg,
  input  wire search_state_t   state,
  input  wire dist_t           side_dist,
  input  wire dist_t           front_dist,
  input  wire logic            clear_search,
  output search_state_t        state_next,
  output action_t              action
);

  search_state_t cur;
  logic          active;
  logic          wall;
  logic          rise;
  logic          fall;
  logic          parked;

  // A clear request starts the step from the reset search state.
  always_comb begin
    if (clear_search) begin
      cur = '{phase: PH_SEARCH, last_side: '0, gap_count: '0, wall_seen: 1'b0};
    end else begin
      cur = state;
    end
  end

  // Edge detection: the side moved by at least the jump since the last step.
  assign rise = {1'b0, side_dist} >= ({1'b0, cur.last_side} + {1'b0, cfg.gap_jump});
  assign fall = ({1'b0, side_dist} + {1'b0, cfg.gap_jump}) <= {1'b0, cur.last_side};
  assign active = (cur.phase == PH_SEARCH) || (cur.phase == PH_COUNT);
  assign wall = cur.wall_seen || (side_dist <= cfg.side_close);

  // Step decision.
  always_comb begin
    state_next = cur;
    action = ACT_FORWARD;
    parked = 1'b0;
    if (!active) begin
      action = ACT_HOLD;
    end else if (front_dist <= cfg.front_stop) begin
      action = ACT_AVOID;
      state_next.last_side = '0;
    end else begin
      if (cur.phase == PH_SEARCH) begin
        state_next.wall_seen = wall;
        if (wall && (side_dist >= cfg.side_far) && rise) begin
          state_next.gap_count = '0;
          state_next.phase = PH_COUNT;
        end
      end else begin
        // Far is tested first, so a reading both far and close keeps counting.
        if (side_dist >= cfg.side_far) begin
          if (cur.gap_count != GAP_COUNT_MAX) begin
            state_next.gap_count = cur.gap_count + 1'b1;
          end
        end else if ((side_dist <= cfg.side_close) && fall) begin
          if (cur.gap_count >= cfg.min_gap) begin
            state_next.phase = PH_PARKED;
            action = ACT_PARK;
            parked = 1'b1;
          end else begin
            state_next.gap_count = '0;
            state_next.wall_seen = 1'b1;
            state_next.phase = PH_SEARCH;
          end
        end
      end
      if (!parked) begin
        state_next.last_side = side_dist;
      end
    end
  end

endmodule

`default_nettype wire

/* test/tb_parking_gap_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parking gap detector unit testbench
// Drives sensor requests through the valid/ready channel in random bursts.
// A behavioural predictor of the search logic works out each command.
// Every returned command is checked field by field against the oldest
// prediction. The run covers the reset thresholds, spare register indexes,
// overlapping thresholds, counter saturation and several random threshold
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_parking_gap_detector_unit;
  import pgd_pkg::*;

  localparam int DIST_MAX = (1 << DIST_W) - 1;
  localparam int PHASE_ITEMS = 190;
  localparam int SHORT_PHASE_ITEMS = 40;
  localparam int RANDOM_SETTINGS = 8;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int REG_SPARE_LO = 5;
  localparam int REG_SPARE_HI = 7;

  typedef struct packed {
    action_t action;
    phase_t phase;
    count_t gap_steps;
  } command_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pgd_in_if sensor_if ();
  pgd_out_if command_if ();

  parking_gap_detector_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sensor(sensor_if),
    .command(command_if)
  );

  // Threshold copies held by the predictor.
  dist_t c_close = SIDE_CLOSE_RST;
  dist_t c_far = SIDE_FAR_RST;
  dist_t c_jump = GAP_JUMP_RST;
  count_t c_min = MIN_GAP_RST;
  dist_t c_front = FRONT_STOP_RST;

  // Search state held by the predictor.
  phase_t m_phase = PH_SEARCH;
  dist_t m_last = '0;
  count_t m_count = '0;
  logic m_wall = 1'b0;

  command_t pending_commands[$];

  int mismatch_count = 0;
  int req_count = 0;
  int cmd_count = 0;
  int parks_seen = 0;
  int avoids_seen = 0;
  int peak_gap = 0;
  int settings_used = 0;
  int burst_left = 0;
  bit steady_sender = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicts the command for one search step and advances the search state.
  function automatic command_t predict_command(input dist_t side, input dist_t front,
                                               input logic clr);
    command_t r;
    int delta;
    bit parked;
    r.action = ACT_FORWARD;
    parked = 1'b0;
    if (clr) begin
      m_phase = PH_SEARCH;
      m_last = '0;
      m_count = '0;
      m_wall = 1'b0;
    end
    if (m_phase == PH_PARKED) begin
      r.action = ACT_HOLD;
    end else if (front <= c_front) begin
      r.action = ACT_AVOID;
      m_last = '0;
    end else begin
      delta = int'(side) - int'(m_last);
      if (m_phase == PH_SEARCH) begin
        if (side <= c_close) m_wall = 1'b1;
        if (m_wall && side >= c_far && delta >= int'(c_jump)) begin
          m_count = '0;
          m_phase = PH_COUNT;
        end
      end else if (side >= c_far) begin
        // The far test wins over the closing edge when thresholds overlap.
        if (m_count != GAP_COUNT_MAX) m_count = m_count + 1'b1;
      end else if (side <= c_close && delta <= -int'(c_jump)) begin
        if (m_count >= c_min) begin
          m_phase = PH_PARKED;
          r.action = ACT_PARK;
          parked = 1'b1;
        end else begin
          m_count = '0;
          m_wall = 1'b1;
          m_phase = PH_SEARCH;
        end
      end
      if (!parked) m_last = side;
    end
    r.phase = m_phase;
    r.gap_steps = m_count;
    return r;
  endfunction

  // Random distance in a range, clipped to the field; any value if the range is empty.
  function automatic dist_t pick_dist(input int lo, input int hi);
    if (lo < 0) lo = 0;
    if (hi > DIST_MAX) hi = DIST_MAX;
    if (lo > hi) return dist_t'($urandom_range(0, DIST_MAX));
    return dist_t'($urandom_range(hi, lo));
  endfunction

  function automatic dist_t front_open();
    return pick_dist(int'(c_front) + 1, DIST_MAX);
  endfunction

  function automatic dist_t front_blocked();
    return pick_dist(0, int'(c_front));
  endfunction

  // Sends one sensor request; the sender idles between bursts of random length.
  task automatic send_request(input dist_t side, input dist_t front, input logic clr);
    int idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle = steady_sender ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      if (idle > 0) begin
        @(negedge clk);
        sensor_if.valid <= 1'b0;
        repeat (idle - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    sensor_if.valid <= 1'b1;
    sensor_if.side_dist <= side;
    sensor_if.front_dist <= front;
    sensor_if.clear_search <= clr;
    do @(posedge clk); while (sensor_if.ready !== 1'b1);
    pending_commands.push_back(predict_command(side, front, clr));
    req_count++;
  endtask

  // Stops sending and waits until every predicted command has come back.
  task automatic wait_idle();
    @(negedge clk);
    sensor_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= reg_index;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (reg_index)
      REG_SIDE_CLOSE: c_close = data;
      REG_SIDE_FAR: c_far = data;
      REG_GAP_JUMP: c_jump = data;
      REG_MIN_GAP: c_min = data[COUNT_W-1:0];
      REG_FRONT_STOP: c_front = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(input dist_t close_cm, input dist_t far_cm, input dist_t jump_cm,
                              input dist_t min_steps, input dist_t stop_cm);
    wait_idle();
    write_reg(REG_SIDE_CLOSE, close_cm);
    write_reg(REG_SIDE_FAR, far_cm);
    write_reg(REG_GAP_JUMP, jump_cm);
    write_reg(REG_MIN_GAP, min_steps);
    write_reg(REG_FRONT_STOP, stop_cm);
    settings_used++;
  endtask

  // One well-formed search: wall, rising edge, gap readings, falling edge.
  task automatic run_gap(input int gap_len, input bit lead_clear, input bit noisy);
    int k;
    int last;
    dist_t side;
    logic clr;
    clr = lead_clear;
    last = 0;
    repeat ($urandom_range(1, 3)) begin
      side = pick_dist(0, int'(c_close));
      send_request(side, front_open(), clr);
      clr = 1'b0;
      last = side;
    end
    side = pick_dist((last + int'(c_jump) > int'(c_far)) ? last + int'(c_jump) : int'(c_far),
                     DIST_MAX);
    send_request(side, front_open(), 1'b0);
    last = side;
    for (k = 0; k < gap_len; k++) begin
      if (noisy && $urandom_range(0, 19) == 0) begin
        send_request(pick_dist(0, DIST_MAX), front_blocked(), 1'b0);
        last = 0;
      end else if (noisy && $urandom_range(0, 7) == 0) begin
        side = pick_dist(0, DIST_MAX);
        send_request(side, front_open(), 1'b0);
        last = side;
      end else begin
        side = pick_dist(int'(c_far), DIST_MAX);
        send_request(side, front_open(), 1'b0);
        last = side;
      end
    end
    side = pick_dist(0, (last - int'(c_jump) < int'(c_close)) ? last - int'(c_jump)
                                                              : int'(c_close));
    send_request(side, front_open(), 1'b0);
    // A latched park should hold whatever arrives next.
    if (m_phase == PH_PARKED) begin
      repeat ($urandom_range(1, 3)) begin
        send_request(pick_dist(0, DIST_MAX), pick_dist(0, DIST_MAX), 1'b0);
      end
    end
  endtask

  // Unstructured requests with an occasional clear.
  task automatic send_noise(input int n);
    repeat (n) begin
      send_request(pick_dist(0, DIST_MAX), pick_dist(0, DIST_MAX),
                   ($urandom_range(0, 7) == 0));
    end
  endtask

  // Reset thresholds: avoid edge, opening, gap accepted, hold, clear, short gap.
  task automatic test_directed_defaults();
    int k;
    send_request(9'd20, 9'd9, 1'b0);
    send_request(9'd511, 9'd8, 1'b0);
    send_request(9'd40, 9'd100, 1'b0);
    for (k = 0; k < 11; k++) begin
      send_request((k == 10) ? 9'd511 : dist_t'(35 + k * 40), 9'd511, 1'b0);
    end
    send_request(9'd30, 9'd200, 1'b0);
    send_request(9'd25, 9'd200, 1'b0);
    send_request(9'd0, 9'd200, 1'b0);
    send_request(9'd0, 9'd0, 1'b0);
    send_request(9'd300, 9'd511, 1'b1);
    send_request(9'd10, 9'd50, 1'b0);
    send_request(9'd50, 9'd50, 1'b0);
    send_request(9'd50, 9'd50, 1'b0);
    send_request(9'd0, 9'd50, 1'b0);
  endtask

  // Writes to unused indexes must leave the thresholds alone.
  task automatic test_spare_indexes();
    wait_idle();
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) begin
      write_reg(CFG_IDX_W'(i),
                CFG_DATA_W'((i == REG_SPARE_LO) ? 9'h1FF : $urandom_range(0, DIST_MAX)));
    end
    run_gap(int'(c_min) + 2, 1'b1, 1'b0);
    run_gap(3, 1'b1, 1'b0);
  endtask

  // Close threshold above far: a reading that is both keeps the count going.
  task automatic test_overlap();
    apply_config(9'd100, 9'd50, 9'd8, 9'd2, 9'd8);
    send_request(9'd40, 9'd200, 1'b1);
    send_request(9'd90, 9'd200, 1'b0);
    send_request(9'd60, 9'd200, 1'b0);
    send_request(9'd60, 9'd200, 1'b0);
    send_request(9'd0, 9'd200, 1'b0);
  endtask

  // Gap count saturates, and only the saturated count meets a minimum of 255.
  task automatic test_saturation();
    apply_config(SIDE_CLOSE_RST, SIDE_FAR_RST, GAP_JUMP_RST, 9'h1FF, FRONT_STOP_RST);
    run_gap(int'(GAP_COUNT_MAX) + 6, 1'b1, 1'b0);
  endtask

  // Random searches and noise under a series of threshold settings.
  task automatic test_random_phases();
    int setting;
    int target;
    int first;
    int close_v;
    int gap_cap;
    for (setting = 0; setting < RANDOM_SETTINGS; setting++) begin
      case (setting)
        0: apply_config(SIDE_CLOSE_RST, SIDE_FAR_RST, GAP_JUMP_RST, dist_t'(MIN_GAP_RST),
                        FRONT_STOP_RST);
        1: begin
          close_v = $urandom_range(5, 150);
          apply_config(dist_t'(close_v), dist_t'(close_v + $urandom_range(1, 100)),
                       dist_t'($urandom_range(1, 60)), dist_t'($urandom_range(0, 30)),
                       dist_t'($urandom_range(0, 100)));
        end
        2: apply_config('0, '0, '0, '0, '0);
        3: begin
          close_v = $urandom_range(100, 300);
          apply_config(dist_t'(close_v), dist_t'($urandom_range(20, close_v - 1)),
                       dist_t'($urandom_range(1, 40)), dist_t'($urandom_range(0, 20)),
                       dist_t'($urandom_range(0, 60)));
        end
        4: apply_config('1, '1, '1, '1, '1);
        5: apply_config('1, '1, '0, 9'd1, dist_t'($urandom_range(0, 20)));
        default: apply_config(dist_t'($urandom_range(0, DIST_MAX)),
                              dist_t'($urandom_range(0, DIST_MAX)),
                              dist_t'($urandom_range(0, 80)),
                              dist_t'($urandom_range(0, DIST_MAX)),
                              dist_t'($urandom_range(0, 120)));
      endcase
      target = (setting == 4) ? SHORT_PHASE_ITEMS : PHASE_ITEMS;
      first = req_count;
      while (req_count - first < target) begin
        steady_sender = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 29) == 0) wait_idle();
        if ($urandom_range(0, 4) == 0) begin
          send_noise($urandom_range(1, 6));
        end else begin
          gap_cap = (int'(c_min) > 40) ? 40 : int'(c_min) + 3;
          run_gap($urandom_range(0, gap_cap),
                  (m_phase == PH_PARKED) || ($urandom_range(0, 7) == 0), 1'b1);
        end
      end
    end
    steady_sender = 1'b0;
  endtask

  // The receiver stalls on a byte-wide pattern that is redrawn at random.
  initial begin
    logic [7:0] stall_pat;
    int tick;
    command_if.ready = 1'b0;
    stall_pat = 8'hFF;
    tick = 0;
    forever begin
      @(negedge clk);
      if (tick % 32 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = 8'hFF;
          1: stall_pat = 8'($urandom_range(0, 255));
          2: stall_pat = 8'($urandom_range(0, 255) & $urandom_range(0, 255));
          default: stall_pat = 8'($urandom_range(0, 255) | $urandom_range(0, 255));
        endcase
        if (stall_pat == 8'h00) stall_pat = 8'h01;
      end
      command_if.ready <= stall_pat[tick % 8];
      tick++;
    end
  end

  // Each command taken is compared with the oldest prediction.
  always @(posedge clk) begin
    command_t want;
    command_t seen;
    if (!rst && command_if.valid === 1'b1 && command_if.ready === 1'b1) begin
      seen.action = command_if.action;
      seen.phase = command_if.phase;
      seen.gap_steps = command_if.gap_steps;
      cmd_count++;
      if (seen.action == ACT_PARK) parks_seen++;
      if (seen.action == ACT_AVOID) avoids_seen++;
      if (int'(seen.gap_steps) > peak_gap) peak_gap = seen.gap_steps;
      if (pending_commands.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("Command %0d arrived with none expected: action %0d phase %0d gap %0d",
                   cmd_count, seen.action, seen.phase, seen.gap_steps);
      end else begin
        want = pending_commands.pop_front();
        if (seen.action !== want.action || seen.phase !== want.phase ||
            seen.gap_steps !== want.gap_steps) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("Command %0d: expected action %0d phase %0d gap %0d, got %0d %0d %0d",
                     cmd_count, want.action, want.phase, want.gap_steps,
                     seen.action, seen.phase, seen.gap_steps);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int drain_wait;
    rst = 1'b1;
    sensor_if.valid = 1'b0;
    sensor_if.side_dist = '0;
    sensor_if.front_dist = '0;
    sensor_if.clear_search = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_defaults();
    test_spare_indexes();
    test_overlap();
    test_saturation();
    test_random_phases();

    // Drain the last commands, then keep watching for stray ones.
    @(negedge clk);
    sensor_if.valid <= 1'b0;
    drain_wait = 0;
    while (pending_commands.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (8) @(posedge clk);
    if (pending_commands.size() != 0) begin
      $display("%0d predicted commands never arrived", pending_commands.size());
      mismatch_count += pending_commands.size();
    end

    $display("Run covered %0d sensor requests over %0d threshold settings.",
             req_count, settings_used);
    $display("Parks %0d, avoid moves %0d, highest gap count %0d, failures %0d.",
             parks_seen, avoids_seen, peak_gap, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_parking_gap_detector_unit: clean");
    end else begin
      $display("tb_parking_gap_detector_unit: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d commands outstanding", pending_commands.size());
    $display("tb_parking_gap_detector_unit: errors");
    $finish;
  end

endmodule
